>>> rtl/rnqc_pkg.sv
// ----------------------------------------------------------------------------
// rnqc_pkg
// Types and constants shared by the regex nested-quantifier checker.
// ----------------------------------------------------------------------------
package rnqc_pkg;

    localparam int CH_W    = 8;
    localparam int LEN_W   = 10;
    localparam int COUNT_W = 11;

    localparam logic [LEN_W-1:0]   MAX_LEN_RESET = LEN_W'(200);
    localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;

    // Pattern characters of interest
    localparam logic [CH_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CH_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [CH_W-1:0] CH_LBRACK = 8'h5B;
    localparam logic [CH_W-1:0] CH_RBRACK = 8'h5D;
    localparam logic [CH_W-1:0] CH_CARET  = 8'h5E;
    localparam logic [CH_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CH_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CH_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CH_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [CH_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CH_W-1:0] CH_TAB    = 8'h09;

    // Verdict codes
    typedef enum logic [1:0] {
        ST_ACCEPT  = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_TOOLONG = 2'd2,
        ST_NESTED  = 2'd3
    } status_t;

    // Scanner mode, one-hot
    typedef enum logic [6:0] {
        M_NORMAL      = 7'b0000001,
        M_ESCAPE      = 7'b0000010,
        M_CLS_OPEN    = 7'b0000100,
        M_CLS_CARET   = 7'b0001000,
        M_CLS_BODY    = 7'b0010000,
        M_CLS_ESC     = 7'b0100000,
        M_AFTER_CLOSE = 7'b1000000
    } scan_mode_t;

endpackage

>>> rtl/rnqc_ifs.sv
// ----------------------------------------------------------------------------
// rnqc_ifs
// Valid/ready channels of the checker: pattern bytes, verdicts, config.
// ----------------------------------------------------------------------------

// Pattern byte channel
interface rnqc_in_if
    import rnqc_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] ch;
    logic            last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

// Verdict channel
interface rnqc_out_if
    import rnqc_pkg::*;
();
    logic    valid;
    logic    ready;
    status_t status;

    modport source (output valid, output status, input ready);
    modport sink   (input valid, input status, output ready);
endinterface

// Config write channel (max_len)
interface rnqc_cfg_if
    import rnqc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/regex_nested_quantifier_check_unit.sv
// ----------------------------------------------------------------------------
// regex_nested_quantifier_check_unit
// Checks a regex pattern, one byte per transfer, and gives one verdict on the
// last byte: accepted, empty, too long or nested quantifiers.
// ----------------------------------------------------------------------------
//  channel | dir | payload          | transfer
//  pat     | in  | ch[7:0], last    | valid && ready
//  verdict | out | status[1:0]      | valid && ready, one per pattern
//  cfg     | in  | data[9:0]        | valid && ready (max_len), ready always 1
//
//  One byte per cycle unless a held verdict stalls the pipe: input register,
//  then the scan state update and verdict register.
//  A verdict passes the input register, then the verdict register.
//  Reset clears the scan state, the pipeline and sets max_len to 200.
//  A held verdict stalls the pipe only when another last byte reaches it.
// ----------------------------------------------------------------------------
module regex_nested_quantifier_check_unit
    import rnqc_pkg::*;
#(
    parameter int NEST_SLOTS = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    rnqc_in_if.sink    pat,
    rnqc_out_if.source verdict,
    rnqc_cfg_if.sink   cfg
);

    logic             s1_valid_reg;
    logic [CH_W-1:0]  s1_ch_reg;
    logic             s1_last_reg;
    logic             out_valid_reg;
    status_t          out_status_reg;
    logic [LEN_W-1:0] max_len_reg;

    logic             s2_take;
    logic             s1_load;
    status_t          scan_status;

    // Pipeline flow control
    assign s2_take   = s1_valid_reg && (!s1_last_reg || !out_valid_reg || verdict.ready);
    assign s1_load   = !s1_valid_reg || s2_take;
    assign pat.ready = s1_load;

    assign cfg.ready      = 1'b1;
    assign verdict.valid  = out_valid_reg;
    assign verdict.status = out_status_reg;

    // Config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_len_reg <= MAX_LEN_RESET;
        else if (cfg.valid)
            max_len_reg <= cfg.data;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_load)
            s1_valid_reg <= pat.valid;
    end

    always_ff @(posedge clk)
    begin
        if (s1_load && pat.valid)
        begin
            s1_ch_reg   <= pat.ch;
            s1_last_reg <= pat.last;
        end
    end

    rnqc_scan #(
        .NEST_SLOTS (NEST_SLOTS)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (s2_take),
        .ch      (s1_ch_reg),
        .last    (s1_last_reg),
        .max_len (max_len_reg),
        .status  (scan_status)
    );

    // Verdict register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s2_take && s1_last_reg)
            out_valid_reg <= 1'b1;
        else if (verdict.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s2_take && s1_last_reg)
            out_status_reg <= scan_status;
    end

endmodule

>>> rtl/rnqc_scan.sv
// ----------------------------------------------------------------------------
// rnqc_scan
// Scan state of one pattern: mode machine, group flag stack, byte count and
// nested flag. Gives the verdict combinationally for the byte being taken.
// ----------------------------------------------------------------------------
module rnqc_scan
    import rnqc_pkg::*;
#(
    parameter int NEST_SLOTS = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  logic [CH_W-1:0]  ch,
    input  logic             last,
    input  logic [LEN_W-1:0] max_len,
    output status_t          status
);

    localparam int DEPTH_W = (NEST_SLOTS > 2) ? $clog2(NEST_SLOTS) : 1;
    localparam logic [DEPTH_W-1:0] DEPTH_TOP = DEPTH_W'(NEST_SLOTS - 1);

    scan_mode_t             mode_reg, mode_next;
    logic [DEPTH_W-1:0]     depth_reg, depth_next;
    // Flag stack; bit 0 is the innermost open group
    logic [NEST_SLOTS-1:0]  stack_reg, stack_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic                   nested_reg, nested_next;

    logic                   do_normal;
    logic                   had_quant;

    // Next scan state for one byte
    always_comb
    begin
        mode_next   = mode_reg;
        depth_next  = depth_reg;
        stack_next  = stack_reg;
        count_next  = count_reg;
        nested_next = nested_reg;
        do_normal   = 1'b0;
        had_quant   = 1'b0;

        if (ch != CH_NUL)
        begin
            if (count_reg != COUNT_MAX)
                count_next = count_reg + COUNT_W'(1);

            unique case (mode_reg)
                M_ESCAPE:
                    mode_next = M_NORMAL;
                M_CLS_OPEN, M_CLS_CARET, M_CLS_BODY:
                begin
                    if (mode_reg == M_CLS_OPEN && ch == CH_CARET)
                        mode_next = M_CLS_CARET;
                    else if (mode_reg != M_CLS_BODY && ch == CH_RBRACK)
                        mode_next = M_CLS_BODY;
                    else if (ch == CH_RBRACK)
                        mode_next = M_NORMAL;
                    else if (ch == CH_BSLASH)
                        mode_next = M_CLS_ESC;
                    else
                        mode_next = M_CLS_BODY;
                end
                M_CLS_ESC:
                    mode_next = M_CLS_BODY;
                M_AFTER_CLOSE:
                begin
                    if (ch != CH_SPACE && ch != CH_TAB)
                    begin
                        if (ch == CH_PLUS || ch == CH_STAR || ch == CH_LBRACE)
                            nested_next = 1'b1;
                        mode_next = M_NORMAL;
                        do_normal = 1'b1;
                    end
                end
                default:
                begin
                    mode_next = M_NORMAL;
                    do_normal = 1'b1;
                end
            endcase

            // Plain pattern byte
            if (do_normal)
            begin
                if (ch == CH_BSLASH)
                    mode_next = M_ESCAPE;
                else if (ch == CH_LBRACK)
                    mode_next = M_CLS_OPEN;
                else if (ch == CH_LPAREN)
                begin
                    if (depth_reg < DEPTH_TOP)
                    begin
                        depth_next = depth_reg + DEPTH_W'(1);
                        stack_next = {stack_reg[NEST_SLOTS-2:0], 1'b0};
                    end
                end
                else if (ch == CH_RPAREN)
                begin
                    if (depth_reg != '0)
                    begin
                        had_quant  = stack_reg[0];
                        depth_next = depth_reg - DEPTH_W'(1);
                        stack_next = {1'b0, stack_reg[NEST_SLOTS-1:1]};
                    end
                    if (had_quant)
                        mode_next = M_AFTER_CLOSE;
                end
                else if (ch == CH_PLUS || ch == CH_STAR)
                begin
                    if (depth_reg != '0)
                        stack_next[0] = 1'b1;
                end
            end
        end
    end

    // Verdict on the updated state
    always_comb
    begin
        if (count_next == '0)
            status = ST_EMPTY;
        else if (count_next > {{(COUNT_W-LEN_W){1'b0}}, max_len})
            status = ST_TOOLONG;
        else if (nested_next)
            status = ST_NESTED;
        else
            status = ST_ACCEPT;
    end

    // State registers; a last byte clears them for the next pattern
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_NORMAL;
            depth_reg  <= '0;
            stack_reg  <= '0;
            count_reg  <= '0;
            nested_reg <= 1'b0;
        end
        else if (take)
        begin
            if (last)
            begin
                mode_reg   <= M_NORMAL;
                depth_reg  <= '0;
                stack_reg  <= '0;
                count_reg  <= '0;
                nested_reg <= 1'b0;
            end
            else
            begin
                mode_reg   <= mode_next;
                depth_reg  <= depth_next;
                stack_reg  <= stack_next;
                count_reg  <= count_next;
                nested_reg <= nested_next;
            end
        end
    end

endmodule

>>> verif/pattern_verdict_checker.sv
// ----------------------------------------------------------------------------
// pattern_verdict_checker
// Watches the pattern, verdict and config channels of the regex checker.
// It tracks the scan state of each pattern as its bytes transfer, works out
// the verdict due on each last byte and compares it with the verdicts that
// the block hands out, in order.
// ----------------------------------------------------------------------------
module pattern_verdict_checker
    import rnqc_pkg::*;
#(
    parameter int NEST_SLOTS = 32
)
(
    input  logic clk,
    input  logic rst_n,
    rnqc_in_if   pat,
    rnqc_out_if  verdict,
    rnqc_cfg_if  cfg,
    output int   errors,
    output int   verdict_count
);

    // Scan state of the pattern in flight
    scan_mode_t         mode;
    int                 open_depth;
    bit                 quant_seen [NEST_SLOTS];
    logic [COUNT_W-1:0] len_count;
    bit                 nest_hit;
    logic [LEN_W-1:0]   len_limit;

    // Verdicts owed by the block, oldest first
    status_t            owed_status[$];

    function automatic void clear_scan();
        mode       = M_NORMAL;
        open_depth = 0;
        foreach (quant_seen[i])
            quant_seen[i] = 1'b0;
        len_count  = '0;
        nest_hit   = 1'b0;
    endfunction

    // Inside a bracket class
    function automatic void class_char(logic [CH_W-1:0] c);
        if (c == CH_RBRACK)
            mode = M_NORMAL;
        else if (c == CH_BSLASH)
            mode = M_CLS_ESC;
        else
            mode = M_CLS_BODY;
    endfunction

    // Outside any class or escape
    function automatic void plain_char(logic [CH_W-1:0] c);
        bit had;
        had = 1'b0;
        if (c == CH_BSLASH)
            mode = M_ESCAPE;
        else if (c == CH_LBRACK)
            mode = M_CLS_OPEN;
        else if (c == CH_LPAREN)
        begin
            // opens past the top slot are dropped
            if (open_depth < NEST_SLOTS - 1)
            begin
                open_depth++;
                quant_seen[open_depth] = 1'b0;
            end
        end
        else if (c == CH_RPAREN)
        begin
            if (open_depth > 0)
            begin
                had = quant_seen[open_depth];
                open_depth--;
            end
            if (had)
                mode = M_AFTER_CLOSE;
        end
        else if (c == CH_PLUS || c == CH_STAR)
        begin
            if (open_depth > 0)
                quant_seen[open_depth] = 1'b1;
        end
    endfunction

    function automatic void scan_char(logic [CH_W-1:0] c);
        case (mode)
            M_ESCAPE:
                mode = M_NORMAL;
            M_CLS_OPEN:
            begin
                if (c == CH_CARET)
                    mode = M_CLS_CARET;
                else if (c == CH_RBRACK)
                    mode = M_CLS_BODY;
                else
                    class_char(c);
            end
            M_CLS_CARET:
            begin
                if (c == CH_RBRACK)
                    mode = M_CLS_BODY;
                else
                    class_char(c);
            end
            M_CLS_BODY:
                class_char(c);
            M_CLS_ESC:
                mode = M_CLS_BODY;
            M_AFTER_CLOSE:
            begin
                // blanks keep the closed group pending
                if (c != CH_SPACE && c != CH_TAB)
                begin
                    if (c == CH_PLUS || c == CH_STAR || c == CH_LBRACE)
                        nest_hit = 1'b1;
                    mode = M_NORMAL;
                    plain_char(c);
                end
            end
            default:
            begin
                mode = M_NORMAL;
                plain_char(c);
            end
        endcase
    endfunction

    // Priority: empty, too long, nested
    function automatic status_t pattern_status();
        if (len_count == '0)
            return ST_EMPTY;
        else if (len_count > COUNT_W'(len_limit))
            return ST_TOOLONG;
        else if (nest_hit)
            return ST_NESTED;
        else
            return ST_ACCEPT;
    endfunction

    // Compare verdict transfers, then follow config and pattern transfers
    always @(posedge clk or negedge rst_n)
    begin
        status_t want;
        if (!rst_n)
        begin
            len_limit = MAX_LEN_RESET;
            clear_scan();
            owed_status.delete();
            errors        <= 0;
            verdict_count <= 0;
        end
        else
        begin
            if (verdict.valid && verdict.ready)
            begin
                verdict_count <= verdict_count + 1;
                if (owed_status.size() == 0)
                begin
                    $error("status: expected none, got %0d", verdict.status);
                    errors <= errors + 1;
                end
                else
                begin
                    want = owed_status.pop_front();
                    if (verdict.status !== want)
                    begin
                        $error("status: expected %0d, got %0d", want, verdict.status);
                        errors <= errors + 1;
                    end
                end
            end

            if (cfg.valid && cfg.ready)
                len_limit = cfg.data;

            if (pat.valid && pat.ready)
            begin
                // zero bytes are neither counted nor scanned
                if (pat.ch != CH_NUL)
                begin
                    if (len_count != COUNT_MAX)
                        len_count = len_count + 1'b1;
                    scan_char(pat.ch);
                end
                if (pat.last)
                begin
                    owed_status.push_back(pattern_status());
                    clear_scan();
                end
            end
        end
    end

endmodule

>>> verif/regex_nested_quantifier_check_unit_test.sv
// ----------------------------------------------------------------------------
// regex_nested_quantifier_check_unit_test
// Drives patterns into the regex checker, a directed set first and then
// random token streams, over several max_len settings with random gaps on
// both channels. The checker module predicts and compares every verdict.
// ----------------------------------------------------------------------------
module regex_nested_quantifier_check_unit_test;
    import rnqc_pkg::*;

    localparam int SLOTS        = 32;
    localparam int RANDOM_ITEMS = 850;
    localparam int CYCLE_LIMIT  = 1_500_000;

    logic clk = 1'b0;
    logic rst_n;

    rnqc_in_if  pat_ch ();
    rnqc_out_if out_ch ();
    rnqc_cfg_if cfg_ch ();

    int fail_count;
    int verdicts_seen;
    int lasts_sent;
    int items_sent;
    int cycle_count;
    int hold_cnt;
    bit stall_on;

    logic [CH_W-1:0] pattern_bytes[$];

    regex_nested_quantifier_check_unit #(
        .NEST_SLOTS (SLOTS)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pat     (pat_ch),
        .verdict (out_ch),
        .cfg     (cfg_ch)
    );

    pattern_verdict_checker #(
        .NEST_SLOTS (SLOTS)
    ) chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .pat           (pat_ch),
        .verdict       (out_ch),
        .cfg           (cfg_ch),
        .errors        (fail_count),
        .verdict_count (verdicts_seen)
    );

    // Clock
    always #2 clk = ~clk;

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 30);
    endfunction

    // Verdict back-pressure
    always @(posedge clk)
    begin
        if (hold_cnt != 0)
            hold_cnt <= hold_cnt - 1;
        else if (!stall_on || !out_ch.ready)
        begin
            out_ch.ready <= 1'b1;
            hold_cnt     <= stall_on ? $urandom_range(0, 12) : 0;
        end
        else
        begin
            out_ch.ready <= 1'b0;
            hold_cnt     <= pick_gap();
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [CH_W-1:0] pick_quant();
        case ($urandom_range(0, 3))
            0:       return CH_PLUS;
            1:       return CH_STAR;
            2:       return CH_LBRACE;
            default: return 8'h61;
        endcase
    endfunction

    function automatic logic [CH_W-1:0] pick_blank();
        return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
    endfunction

    // Bracket class, sometimes left open
    function automatic void add_class();
        pattern_bytes.push_back(CH_LBRACK);
        if ($urandom_range(0, 2) == 0)
            pattern_bytes.push_back(CH_CARET);
        if ($urandom_range(0, 2) == 0)
            pattern_bytes.push_back(CH_RBRACK);
        repeat ($urandom_range(0, 3))
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    pattern_bytes.push_back(CH_BSLASH);
                    pattern_bytes.push_back(8'($urandom_range(0, 255)));
                end
                1:       pattern_bytes.push_back(CH_LPAREN);
                2:       pattern_bytes.push_back(CH_PLUS);
                default: pattern_bytes.push_back(8'h61 + 8'($urandom_range(0, 25)));
            endcase
        end
        if ($urandom_range(0, 7) != 0)
            pattern_bytes.push_back(CH_RBRACK);
    endfunction

    // One regex token, biased toward groups and quantifiers
    function automatic void add_token();
        int r;
        r = $urandom_range(0, 99);
        if (r < 18)
            pattern_bytes.push_back(8'h61 + 8'($urandom_range(0, 25)));
        else if (r < 30)
            pattern_bytes.push_back(CH_LPAREN);
        else if (r < 44)
        begin
            pattern_bytes.push_back(CH_RPAREN);
            repeat ($urandom_range(0, 2))
                pattern_bytes.push_back(pick_blank());
            if ($urandom_range(0, 2) != 0)
                pattern_bytes.push_back(pick_quant());
        end
        else if (r < 56)
            pattern_bytes.push_back($urandom_range(0, 1) ? CH_PLUS : CH_STAR);
        else if (r < 60)
            pattern_bytes.push_back(CH_LBRACE);
        else if (r < 64)
            pattern_bytes.push_back(pick_blank());
        else if (r < 70)
        begin
            pattern_bytes.push_back(CH_BSLASH);
            pattern_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else if (r < 80)
            add_class();
        else if (r < 82)
        begin
            // run of 28 to 36 opens, around the slot count and at times past it
            repeat ($urandom_range(28, 36))
                pattern_bytes.push_back(CH_LPAREN);
        end
        else if (r < 85)
            pattern_bytes.push_back(CH_NUL);
        else
            pattern_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void load_text(string s);
        pattern_bytes.delete();
        for (int i = 0; i < s.len(); i++)
            pattern_bytes.push_back(s[i]);
    endfunction

    // Mostly token streams, some raw noise
    function automatic void make_random_pattern();
        pattern_bytes.delete();
        if ($urandom_range(0, 4) != 0)
        begin
            repeat ($urandom_range(0, 14))
                add_token();
        end
        else
        begin
            repeat ($urandom_range(1, 10))
                pattern_bytes.push_back(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 9) == 0)
            pattern_bytes.push_back(CH_NUL);
    endfunction

    task automatic send_byte(input logic [CH_W-1:0] c, input logic is_last);
        int gap;
        gap = stall_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            pat_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pat_ch.valid <= 1'b1;
        pat_ch.ch    <= c;
        pat_ch.last  <= is_last;
        do
            @(posedge clk);
        while (!pat_ch.ready);
        items_sent++;
        if (is_last)
            lasts_sent++;
    endtask

    // An empty pattern goes out as a lone zero byte
    task automatic send_pattern();
        if (pattern_bytes.size() == 0)
            send_byte(CH_NUL, 1'b1);
        else
            foreach (pattern_bytes[i])
                send_byte(pattern_bytes[i], i == pattern_bytes.size() - 1);
    endtask

    task automatic write_max_len(input logic [LEN_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // Wait for every owed verdict, then let the pipe settle
    task automatic drain();
        pat_ch.valid <= 1'b0;
        while (verdicts_seen < lasts_sent)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic random_phase(input logic [LEN_W-1:0] limit, input int count);
        write_max_len(limit);
        repeat (count)
        begin
            make_random_pattern();
            send_pattern();
        end
        drain();
    endtask

    // Stimulus
    initial
    begin
        int r;
        int target;
        logic [LEN_W-1:0] limit;

        rst_n        <= 1'b0;
        pat_ch.valid <= 1'b0;
        pat_ch.ch    <= CH_NUL;
        pat_ch.last  <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data  <= '0;
        stall_on     <= 1'b0;
        lasts_sent    = 0;
        items_sent    = 0;
        repeat (4) @(posedge clk);
        rst_n    <= 1'b1;
        stall_on <= 1'b1;
        @(posedge clk);

        // Directed set at the reset length limit
        load_text("");
        send_pattern();
        load_text("(a+)+");
        send_pattern();
        load_text("(b*) \t{");
        send_pattern();
        load_text("[^](+)]*");
        send_pattern();
        load_text(")*");
        send_pattern();
        load_text("a\\");
        send_pattern();
        load_text("[x");
        send_pattern();
        drain();

        // Zero and one byte limits
        random_phase(LEN_W'(0), 12);
        random_phase(LEN_W'(1), 12);

        // Full limit
        write_max_len(LEN_W'(1023));
        load_text("((a*)b)*");
        send_pattern();
        drain();

        // Random phases over assorted limits
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
                limit = LEN_W'($urandom_range(0, 2));
            else if (r < 70)
                limit = LEN_W'($urandom_range(4, 40));
            else if (r < 85)
                limit = MAX_LEN_RESET;
            else
                limit = LEN_W'($urandom_range(0, 1023));
            stall_on <= ($urandom_range(0, 3) != 0);
            random_phase(limit, $urandom_range(10, 25));
        end

        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> filelist.f
rtl/rnqc_pkg.sv
rtl/rnqc_ifs.sv
rtl/rnqc_scan.sv
rtl/regex_nested_quantifier_check_unit.sv
verif/pattern_verdict_checker.sv
verif/regex_nested_quantifier_check_unit_test.sv
